/* design/pgmsp_pkg.sv */
`timescale 1ns / 1ps

package pgmsp_pkg;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam int unsigned VALUE_W = 16;

    typedef enum logic [2:0] {
        PH_MAGIC  = 3'd0,
        PH_WIDTH  = 3'd1,
        PH_HEIGHT = 3'd2,
        PH_GREY   = 3'd3,
        PH_IMAGE  = 3'd4,
        PH_STOP   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        KIND_WIDTH  = 3'd0,
        KIND_HEIGHT = 3'd1,
        KIND_GREY   = 3'd2,
        KIND_PIXEL  = 3'd3,
        KIND_ERROR  = 3'd4
    } t_kind;

    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic               row_end;
    } t_result;

    function automatic logic is_eol(input logic [7:0] b);
        return (b == CH_LF) || (b == CH_CR);
    endfunction

endpackage

/* design/pgmsp_step.sv */
`timescale 1ns / 1ps

module pgmsp_step #(
    parameter int unsigned DIM_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    input  logic                i_start,
    output pgmsp_pkg::t_result  o_result
);

    localparam int unsigned AccW = (DIM_BITS >= 16) ? 16 : DIM_BITS;
    localparam int unsigned SumW = AccW + 6;

    pgmsp_pkg::t_phase r_phase, n_phase, e_phase;
    logic              r_comment, n_comment, e_comment;
    logic              r_allowed, n_allowed, e_allowed;
    logic [1:0]        r_magic, n_magic, e_magic;
    logic [AccW-1:0]   r_acc, n_acc, e_acc;
    logic [AccW-1:0]   r_width, n_width, e_width;
    logic [AccW-1:0]   r_col, n_col, e_col;

    logic                   eol;
    logic                   skip;
    logic                   magic_ok;
    logic [7:0]             magic_exp;
    logic [SumW-1:0]        mul10;
    logic signed [SumW-1:0] sum;
    logic [AccW-1:0]        acc_next;
    logic [AccW-1:0]        col_inc;

    // restart from the reset values when a new file begins
    always_comb begin
        e_phase   = i_start ? pgmsp_pkg::PH_MAGIC : r_phase;
        e_comment = i_start ? 1'b0 : r_comment;
        e_allowed = i_start ? 1'b1 : r_allowed;
        e_magic   = i_start ? 2'd0 : r_magic;
        e_acc     = i_start ? '0   : r_acc;
        e_width   = i_start ? '0   : r_width;
        e_col     = i_start ? '0   : r_col;
    end

    assign eol       = pgmsp_pkg::is_eol(i_byte);
    assign skip      = (e_phase == pgmsp_pkg::PH_STOP) || e_comment
                       || (e_allowed && (i_byte == pgmsp_pkg::CH_HASH));
    assign magic_exp = (e_magic == 2'd0) ? pgmsp_pkg::CH_P : pgmsp_pkg::CH_FIVE;
    assign magic_ok  = (e_magic != 2'd2) && (i_byte == magic_exp);

    assign mul10 = (SumW'(e_acc) << 3) + (SumW'(e_acc) << 1);
    assign sum   = $signed(mul10) + $signed(SumW'(i_byte))
                   - $signed(SumW'(pgmsp_pkg::CH_ZERO));

    always_comb begin
        if (sum[SumW-1]) begin
            acc_next = '0;
        end else if (sum[SumW-2:AccW] != '0) begin
            acc_next = '1;
        end else begin
            acc_next = sum[AccW-1:0];
        end
    end

    assign col_inc = e_col + AccW'(1);

    always_comb begin
        n_phase = e_phase;
        if (!skip) begin
            unique case (e_phase)
                pgmsp_pkg::PH_MAGIC: begin
                    if (eol) begin
                        n_phase = pgmsp_pkg::PH_WIDTH;
                    end else if (!magic_ok) begin
                        n_phase = pgmsp_pkg::PH_STOP;
                    end
                end
                pgmsp_pkg::PH_WIDTH: begin
                    if (i_byte == pgmsp_pkg::CH_SPACE) begin
                        n_phase = pgmsp_pkg::PH_HEIGHT;
                    end
                end
                pgmsp_pkg::PH_HEIGHT: begin
                    if (eol) begin
                        n_phase = pgmsp_pkg::PH_GREY;
                    end
                end
                pgmsp_pkg::PH_GREY: begin
                    if (eol) begin
                        n_phase = pgmsp_pkg::PH_IMAGE;
                    end
                end
                pgmsp_pkg::PH_IMAGE: begin
                    n_phase = pgmsp_pkg::PH_IMAGE;
                end
                default: begin
                    n_phase = pgmsp_pkg::PH_STOP;
                end
            endcase
        end
    end

    always_comb begin
        n_comment = e_comment;
        n_allowed = e_allowed;
        n_magic   = e_magic;
        n_acc     = e_acc;
        n_width   = e_width;
        n_col     = e_col;
        o_result  = '{valid: 1'b0, kind: pgmsp_pkg::KIND_ERROR, value: '0, row_end: 1'b0};
        if (e_phase == pgmsp_pkg::PH_STOP) begin
            n_comment = e_comment;
        end else if (e_comment) begin
            if (eol) begin
                n_comment = 1'b0;
            end
        end else if (e_allowed && (i_byte == pgmsp_pkg::CH_HASH)) begin
            n_comment = 1'b1;
        end else begin
            unique case (e_phase)
                pgmsp_pkg::PH_MAGIC: begin
                    if (!eol) begin
                        if (magic_ok) begin
                            n_magic = e_magic + 2'd1;
                        end else begin
                            o_result.valid = 1'b1;
                        end
                    end
                end
                pgmsp_pkg::PH_WIDTH: begin
                    n_allowed = 1'b0;
                    if (i_byte == pgmsp_pkg::CH_SPACE) begin
                        n_width        = e_acc;
                        n_acc          = '0;
                        o_result.valid = 1'b1;
                        o_result.kind  = pgmsp_pkg::KIND_WIDTH;
                        o_result.value = pgmsp_pkg::VALUE_W'(e_acc);
                    end else begin
                        n_acc = acc_next;
                    end
                end
                pgmsp_pkg::PH_HEIGHT,
                pgmsp_pkg::PH_GREY: begin
                    if (eol) begin
                        n_acc          = '0;
                        o_result.valid = 1'b1;
                        o_result.value = pgmsp_pkg::VALUE_W'(e_acc);
                        if (e_phase == pgmsp_pkg::PH_GREY) begin
                            n_col         = '0;
                            o_result.kind = pgmsp_pkg::KIND_GREY;
                        end else begin
                            o_result.kind = pgmsp_pkg::KIND_HEIGHT;
                        end
                    end else begin
                        n_acc = acc_next;
                    end
                end
                pgmsp_pkg::PH_IMAGE: begin
                    o_result.valid = 1'b1;
                    o_result.kind  = pgmsp_pkg::KIND_PIXEL;
                    o_result.value = pgmsp_pkg::VALUE_W'(i_byte);
                    if ((e_width != '0) && (col_inc == e_width)) begin
                        n_col            = '0;
                        o_result.row_end = 1'b1;
                    end else begin
                        n_col = col_inc;
                    end
                end
                default: begin
                    n_comment = e_comment;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= pgmsp_pkg::PH_MAGIC;
            r_comment <= 1'b0;
            r_allowed <= 1'b1;
            r_magic   <= 2'd0;
            r_acc     <= '0;
            r_width   <= '0;
            r_col     <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_comment <= n_comment;
            r_allowed <= n_allowed;
            r_magic   <= n_magic;
            r_acc     <= n_acc;
            r_width   <= n_width;
            r_col     <= n_col;
        end
    end

endmodule

/* design/pgm_stream_parser.sv */
`timescale 1ns / 1ps

// Binary PGM (P5) header parser: one file byte per transfer in, zero or one
// result per byte out (width, height, max grey, pixel with end-of-row mark,
// or a format error, after which bytes are dropped until tuser marks a new
// file). It takes one byte every cycle unless stalled; each result is
// registered: the input register holds the byte until the parser state
// update loads the result register from it. A held result stalls the input
// only once both registers are full. Header numbers saturate at
// 2^DIM_BITS-1, capped at 65535.
module pgm_stream_parser #(
    parameter int unsigned DIM_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_in
    input  logic        s_tuser,   // file_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // value
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast    // row_end
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_start;
    logic               r_out_valid;
    pgmsp_pkg::t_kind   r_out_kind;
    logic [15:0]        r_out_value;
    logic               r_out_row_end;
    logic               advance;
    logic               fire;
    pgmsp_pkg::t_result result;

    assign advance  = !r_out_valid || m_tready;
    assign fire     = r_in_valid && advance;
    assign s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_byte  <= s_tdata;
            r_in_start <= s_tuser;
        end
    end

    pgmsp_step #(
        .DIM_BITS (DIM_BITS)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .i_start  (r_in_start),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && result.valid) begin
            r_out_kind    <= result.kind;
            r_out_value   <= result.value;
            r_out_row_end <= result.row_end;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_value;
    assign m_tuser  = r_out_kind;
    assign m_tlast  = r_out_row_end;

`ifndef SYNTHESIS
    a_last_only_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tlast |-> m_tuser == pgmsp_pkg::KIND_PIXEL)
        else $error("row end on a non-pixel result");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == pgmsp_pkg::KIND_ERROR) |-> m_tdata == 16'd0)
        else $error("format error carries a value");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !m_tready |-> !s_tready)
        else $error("input taken while both stages are held");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("held result changed");
`endif

endmodule
